// ----- rtl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the streaming top-k score selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

  // signed Q16.16 score
  typedef logic signed [31:0] score_t;

  // register index of top_count in the configuration map
  localparam logic REG_TOP_COUNT = 1'b0;

  localparam logic [3:0] TOP_COUNT_RESET = 4'd5;

  // control for the keep row
  typedef struct packed {
    logic insert;   // new score enters the sorted row
    logic clear;    // row empties after this item
  } keep_ctl_t;

  // control for the drain row
  typedef struct packed {
    logic load;     // snapshot of the sorted row is taken
    logic shift;    // head entry is taken, row moves one place forward
  } drain_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tks_keep_cell.sv -----
// ----------------------------------------------------------------------------
// tks_keep_cell
// One slot of the sorted insertion row: compares the incoming score with
// its own and either holds, takes the new score or takes its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_keep_cell #(
  parameter int IDX_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tks_pkg::keep_ctl_t   ctl,
  input  wire tks_pkg::score_t      new_score,
  input  wire logic [IDX_W-1:0]     new_pos,
  // left neighbor (higher rank), current contents
  input  wire logic                 left_valid,
  input  wire logic                 left_beats,
  input  wire tks_pkg::score_t      left_score,
  input  wire logic [IDX_W-1:0]     left_pos,
  // own contents
  output logic                      valid,
  output logic                      beats,
  output tks_pkg::score_t           score,
  output logic [IDX_W-1:0]          pos,
  // contents after this item's insertion, before clearing
  output logic                      valid_nxt,
  output tks_pkg::score_t           score_nxt,
  output logic [IDX_W-1:0]          pos_nxt
);
  import tks_pkg::*;

  logic             valid_r;
  score_t           score_r;
  logic [IDX_W-1:0] pos_r;

  // strictly greater wins; ties keep the earlier position
  assign beats = !valid_r || (new_score > score_r);

  // insertion: shift in from the left or take the new score
  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    pos_nxt   = pos_r;
    if (ctl.insert && beats) begin
      if (left_beats) begin
        // an empty left slot hands over an empty entry
        valid_nxt = left_valid;
        score_nxt = left_score;
        pos_nxt   = left_pos;
      end else begin
        valid_nxt = 1'b1;
        score_nxt = new_score;
        pos_nxt   = new_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    pos_r   <= pos_nxt;
  end

  assign valid = valid_r;
  assign score = score_r;
  assign pos   = pos_r;

endmodule

`default_nettype wire

// ----- rtl/tks_drain_cell.sv -----
// ----------------------------------------------------------------------------
// tks_drain_cell
// One slot of the result row: loads a snapshot of the sorted row and moves
// toward the head one place per taken result.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_drain_cell #(
  parameter int IDX_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tks_pkg::drain_ctl_t  ctl,
  input  wire logic                 load_valid,
  input  wire tks_pkg::score_t      load_score,
  input  wire logic [IDX_W-1:0]     load_pos,
  // right neighbor (next lower rank)
  input  wire logic                 right_valid,
  input  wire tks_pkg::score_t      right_score,
  input  wire logic [IDX_W-1:0]     right_pos,
  output logic                      valid,
  output tks_pkg::score_t           score,
  output logic [IDX_W-1:0]          pos
);
  import tks_pkg::*;

  logic             valid_r;
  score_t           score_r;
  logic [IDX_W-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= load_valid;
    end else if (ctl.shift) begin
      valid_r <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      score_r <= load_score;
      pos_r   <= load_pos;
    end else if (ctl.shift) begin
      score_r <= right_score;
      pos_r   <= right_pos;
    end
  end

  assign valid = valid_r;
  assign score = score_r;
  assign pos   = pos_r;

endmodule

`default_nettype wire

// ----- rtl/top_k_score_select.sv -----
// ----------------------------------------------------------------------------
// top_k_score_select
// Streaming top-k selector: keeps the best scores of a vector in a sorted
// row of compare-and-shift cells and reports them, best first, at its end.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid, in_stall, in_score,           | input item
//           | in_final_item                           |
//  out      | out_valid, out_stall, out_class_index,  | result item
//           | out_class_score, out_rank_last          |
//  cfg      | cfg_psel .. cfg_pready (APB-style)      | register
//
//  One item is accepted per cycle while in_stall is low; insertion into the sorted row
//  is done in the accept cycle by all cells in parallel.
//  A final item snapshots the row into the result row; results leave one
//  per cycle from its head while out_stall is low.
//  A final item is stalled only while results of the previous vector are
//  still queued; other items keep flowing during draining.
//  Synchronous active-low reset empties both rows and sets top_count to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_select #(
  parameter int MAX_KEEP  = 8,
  parameter int MAX_ITEMS = 1024,
  parameter int IDX_W     = $clog2(MAX_ITEMS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tks_pkg::score_t     in_score,
  input  wire logic                in_final_item,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [IDX_W-1:0]         out_class_index,
  output tks_pkg::score_t          out_class_score,
  output logic                     out_rank_last,
  // configuration port
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import tks_pkg::*;

  localparam int CNT_W = IDX_W + 1;

  // configuration register
  logic [3:0] top_count_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_TOP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RESET;
    end else if (cfg_wr) begin
      top_count_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TOP_COUNT) ? {28'd0, top_count_r} : 32'd0;

  // input handshake and position counter
  logic             in_acc;
  logic [CNT_W-1:0] pos_cnt_r;
  logic             in_range;
  logic             d_valid [MAX_KEEP+1];

  assign in_stall = d_valid[0] && in_final_item;
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (pos_cnt_r != CNT_W'(MAX_ITEMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
    end else if (in_acc) begin
      if (in_final_item) begin
        pos_cnt_r <= '0;
      end else if (in_range) begin
        pos_cnt_r <= pos_cnt_r + CNT_W'(1);
      end
    end
  end

  keep_ctl_t  kctl;
  drain_ctl_t dctl;

  assign kctl.insert = in_acc && in_range;
  assign kctl.clear  = in_acc && in_final_item;
  assign dctl.load   = in_acc && in_final_item;
  assign dctl.shift  = out_valid && !out_stall;

  // keep row: cell 0 holds the best entry (slot 1 of the k_* arrays)
  logic             k_valid [MAX_KEEP+1];
  logic             k_beats [MAX_KEEP+1];
  score_t           k_score [MAX_KEEP+1];
  logic [IDX_W-1:0] k_pos   [MAX_KEEP+1];
  logic             kn_valid [MAX_KEEP];
  score_t           kn_score [MAX_KEEP];
  logic [IDX_W-1:0] kn_pos   [MAX_KEEP];

  score_t           d_score [MAX_KEEP+1];
  logic [IDX_W-1:0] d_pos   [MAX_KEEP+1];

  // slot 0 of the k_* arrays is the left border, which never beats
  assign k_valid[0] = 1'b1;
  assign k_beats[0] = 1'b0;
  assign k_score[0] = '0;
  assign k_pos[0]   = '0;
  // slot MAX_KEEP of the d_* arrays is the empty right border
  assign d_valid[MAX_KEEP] = 1'b0;
  assign d_score[MAX_KEEP] = '0;
  assign d_pos[MAX_KEEP]   = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic keep_en;

    tks_keep_cell #(.IDX_W(IDX_W)) u_keep (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (kctl),
      .new_score  (in_score),
      .new_pos    (pos_cnt_r[IDX_W-1:0]),
      .left_valid (k_valid[i]),
      .left_beats (k_beats[i]),
      .left_score (k_score[i]),
      .left_pos   (k_pos[i]),
      .valid      (k_valid[i+1]),
      .beats      (k_beats[i+1]),
      .score      (k_score[i+1]),
      .pos        (k_pos[i+1]),
      .valid_nxt  (kn_valid[i]),
      .score_nxt  (kn_score[i]),
      .pos_nxt    (kn_pos[i])
    );

    // only the first top_count entries are reported; zero acts as one
    assign keep_en = kn_valid[i] && ((i == 0) || ({28'd0, top_count_r} > 32'(i)));

    tks_drain_cell #(.IDX_W(IDX_W)) u_drain (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (dctl),
      .load_valid  (keep_en),
      .load_score  (kn_score[i]),
      .load_pos    (kn_pos[i]),
      .right_valid (d_valid[i+1]),
      .right_score (d_score[i+1]),
      .right_pos   (d_pos[i+1]),
      .valid       (d_valid[i]),
      .score       (d_score[i]),
      .pos         (d_pos[i])
    );
  end

  // head of the result row drives the output channel
  assign out_valid       = d_valid[0];
  assign out_class_index = d_pos[0];
  assign out_class_score = d_score[0];
  assign out_rank_last   = !d_valid[1];

endmodule

`default_nettype wire

// ----- test/top_k_score_select_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_select_tb
// Self-checking bench for the streaming top-k selector. Score vectors go in
// through a queue-fed driver. A scoreboard keeps its own sorted top-k list,
// builds the ranked results of each vector and compares them, field by field
// and in order, with what leaves the result channel. top_count is rewritten
// between phases, mid-vector too, and both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_select_tb;
  import tks_pkg::*;

  localparam int KEEP_DEPTH = 8;
  localparam int ITEM_LIMIT = 1024;
  localparam int SETTLE_CYCLES = 16;

  // one input item and one ranked result
  typedef struct {
    score_t score;
    logic   final_item;
  } score_item_t;

  typedef struct {
    logic [9:0] class_index;
    score_t     class_score;
    logic       rank_last;
  } ranked_t;

  // mix of score values within one vector
  typedef enum int {SC_WIDE, SC_TIES, SC_EDGE, SC_Q16} score_mix_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  score_t      in_score = '0;
  logic        in_final_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_class_index;
  score_t      out_class_score;
  logic        out_rank_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // bench state
  score_item_t score_queue [$];
  ranked_t     ranked_due [$];
  score_item_t next_item;
  ranked_t     want;
  logic        in_taken = 1'b0;
  int          send_idle_pct = 21;
  int          recv_stall_pct = 63;
  int          mismatches = 0;

  // scoreboard copy of the sorted list and the register
  score_t      keep_scores [KEEP_DEPTH];
  logic [9:0]  keep_index [KEEP_DEPTH];
  int          keep_count = 0;
  int          vec_position = 0;
  logic [3:0]  top_count = TOP_COUNT_RESET;

  top_k_score_select i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_score        (in_score),
    .in_final_item   (in_final_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_index (out_class_index),
    .out_class_score (out_class_score),
    .out_rank_last   (out_rank_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // insert one accepted score; a final item emits the ranked run
  function automatic void take_score(score_t s, logic fin);
    int p;
    int j;
    int k;
    int n;
    ranked_t r;
    if (vec_position < ITEM_LIMIT) begin
      p = 0;
      // ties keep the earlier position in front
      while (p < keep_count && keep_scores[p] >= s) p++;
      if (p < KEEP_DEPTH) begin
        j = (keep_count < KEEP_DEPTH) ? keep_count : KEEP_DEPTH - 1;
        while (j > p) begin
          keep_scores[j] = keep_scores[j-1];
          keep_index[j]  = keep_index[j-1];
          j--;
        end
        keep_scores[p] = s;
        keep_index[p]  = vec_position[9:0];
        if (keep_count < KEEP_DEPTH) keep_count++;
      end
      vec_position++;
    end
    if (fin) begin
      // zero acts as one, anything above the depth as the depth
      k = (top_count == 0) ? 1 : (int'(top_count) > KEEP_DEPTH) ? KEEP_DEPTH : int'(top_count);
      n = (k < keep_count) ? k : keep_count;
      for (int i = 0; i < n; i++) begin
        r.class_index = keep_index[i];
        r.class_score = keep_scores[i];
        r.rank_last   = (i == n - 1);
        ranked_due.insert(ranked_due.size(), r);
      end
      keep_count   = 0;
      vec_position = 0;
    end
  endfunction

  function automatic score_t pick_score(score_mix_t mix);
    score_t s;
    case (mix)
      SC_WIDE: s = $urandom;
      SC_TIES: s = $signed($urandom_range(6, 0)) - 3;
      SC_EDGE: begin
        case ($urandom_range(5, 0))
          0: s = 32'sh7fffffff;
          1: s = 32'sh80000000;
          2: s = 32'sh0;
          3: s = -32'sd1;
          4: s = 32'sd1;
          default: s = 32'sh80000001;
        endcase
      end
      default: s = $signed($urandom_range(32'h140000, 0)) - 32'sh000a0000;
    endcase
    return s;
  endfunction

  function automatic void push_item(score_t s, logic fin);
    score_item_t it;
    it.score = s;
    it.final_item = fin;
    score_queue.insert(score_queue.size(), it);
  endfunction

  // one vector of random content; fin_at_end low leaves it open
  function automatic void push_vector(int len, logic fin_at_end);
    score_mix_t mix;
    score_mix_t pick;
    mix = score_mix_t'($urandom_range(3, 0));
    for (int i = 0; i < len; i++) begin
      pick = ($urandom_range(7, 0) == 0) ? score_mix_t'($urandom_range(3, 0)) : mix;
      push_item(pick_score(pick), fin_at_end && (i == len - 1));
    end
  endfunction

  // wait until every item is in and every result is out
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (score_queue.size() != 0 || in_valid || ranked_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_top_count(logic [3:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TOP_COUNT, 2'b00};
    cfg_pwdata  <= 32'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    top_count = v;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // random vectors, with an occasional register change in between
  task automatic random_phase(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 13) : $urandom_range(10, 1);
      push_vector(len, 1'b1);
      sent += len;
      if ($urandom_range(5, 0) == 0) begin
        settle();
        write_top_count($urandom_range(15, 0));
      end
    end
  endtask

  // open a vector, change top_count halfway, then close it
  task automatic split_vector(logic [3:0] v);
    push_vector($urandom_range(6, 2), 1'b0);
    settle();
    write_top_count(v);
    push_vector($urandom_range(8, 1), 1'b1);
  endtask

  // driver: new item on the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (score_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_item = score_queue.pop_front();
        in_valid      <= 1'b1;
        in_score      <= next_item.score;
        in_final_item <= next_item.final_item;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // monitor: check results, feed accepted items to the scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (ranked_due.size() == 0) begin
          $display("%0t: unexpected result index %0d score %0d", $time,
                   out_class_index, out_class_score);
          mismatches++;
        end else begin
          want = ranked_due.pop_front();
          if (out_class_index !== want.class_index) begin
            $display("%0t: class_index expected %0d got %0d", $time,
                     want.class_index, out_class_index);
            mismatches++;
          end
          if (out_class_score !== want.class_score) begin
            $display("%0t: class_score expected %0d got %0d", $time,
                     want.class_score, out_class_score);
            mismatches++;
          end
          if (out_rank_last !== want.rank_last) begin
            $display("%0t: rank_last expected %0b got %0b", $time,
                     want.rank_last, out_rank_last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) take_score(in_score, in_final_item);
    end
  end

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single item at reset count
    push_item(32'sh80000000, 1'b1);
    // extremes and ties, more items than top_count
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sh80000000, 1'b0);
    push_item(32'sh0, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sh0, 1'b0);
    push_item(32'sh80000001, 1'b1);
    // equal scores, fewer than top_count
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b1);
    settle();

    write_top_count(4'd1);
    push_item(-32'sd7, 1'b0);
    push_item(32'sh00010000, 1'b0);
    push_item(32'sh00010000, 1'b1);
    settle();

    // rising scores: every item enters at the head, list overflows
    write_top_count(4'd8);
    for (int i = 0; i < 9; i++) push_item(32'sh7ffffff0 + i, i == 8);
    settle();

    write_top_count(4'd0);
    push_item(32'sh80000000, 1'b0);
    push_item(32'sh80000000, 1'b1);
    settle();

    // sender 21%, receiver 63%
    split_vector(4'd15);
    random_phase(90);
    settle();

    // sender 63%, receiver 21%
    send_idle_pct  = 63;
    recv_stall_pct = 21;
    split_vector(4'd9);
    random_phase(90);
    settle();

    // no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    split_vector(4'd2);
    random_phase(90);
    settle();

    if (mismatches == 0) begin
      $display("top_k_score_select: match");
    end else begin
      $display("top_k_score_select: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("top_k_score_select: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
